// File: design/erld_pkg.sv
// shared types and constants of the escape run-length decoder
`default_nettype none
package erld_pkg;

  localparam logic [7:0] ESC_BYTE        = 8'hFF;
  localparam logic [7:0] SHORT_RUN_LIMIT = 8'd3;
  localparam int         RUN_W           = 9;   // run length 0..256
  localparam int         MAX_RESULTS     = 64;
  localparam int         CHUNK_W         = 6;   // chunk index 0..63
  localparam int         FIELD_LANES     = 4;
  localparam int         CNT_W           = 3;   // valid lane count 0..4
  localparam int         BLEN_W          = 24;

  // decode phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ESC  = 3'b010,
    PH_CNT  = 3'b100
  } phase_t;

  // emitter sequencer states, one-hot
  typedef enum logic [1:0] {
    EM_IDLE = 2'b01,
    EM_RUN  = 2'b10
  } emit_state_t;

  // one decoded run handed from the parser to the emitter
  typedef struct packed {
    logic [7:0]        value;
    logic [RUN_W-1:0]  len;
    logic              blk_end;
    logic [BLEN_W-1:0] blk_len;
    logic              trunc;
  } run_t;

endpackage
`default_nettype wire

// File: design/erld_parse.sv
// escape parser: phase tracking and saturating block length
`default_nettype none
module erld_parse #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_block_end,
  output erld_pkg::run_t           run
);

  erld_pkg::phase_t                  phase_r, phase_nxt;
  logic [7:0]                        pend_r, pend_nxt;
  logic [LENGTH_BITS-1:0]            len_r, len_new;
  logic [LENGTH_BITS:0]              len_sum;
  logic [LENGTH_BITS+erld_pkg::BLEN_W-1:0] len_ext;
  logic [7:0]                        run_val;
  logic [erld_pkg::RUN_W-1:0]        run_len;

  always_comb begin
    run_val   = '0;
    run_len   = '0;
    phase_nxt = erld_pkg::PH_IDLE;
    pend_nxt  = pend_r;
    unique case (phase_r)
      erld_pkg::PH_ESC: begin
        pend_nxt = in_byte;
        if (in_byte < erld_pkg::SHORT_RUN_LIMIT) begin
          run_val = erld_pkg::ESC_BYTE;
          run_len = {1'b0, in_byte} + 9'd1;
        end else begin
          phase_nxt = erld_pkg::PH_CNT;
        end
      end
      erld_pkg::PH_CNT: begin
        run_val = in_byte;
        run_len = {1'b0, pend_r} + 9'd1;
      end
      default: begin
        // idle, and any code that means nothing
        if (in_byte == erld_pkg::ESC_BYTE) begin
          phase_nxt = erld_pkg::PH_ESC;
        end else begin
          run_val = in_byte;
          run_len = 9'd1;
        end
      end
    endcase
  end

  assign len_sum = {1'b0, len_r} + (LENGTH_BITS+1)'(run_len);
  assign len_new = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
  assign len_ext = {{erld_pkg::BLEN_W{1'b0}}, len_new};

  always_comb begin
    run.value   = run_val;
    run.len     = run_len;
    run.blk_end = in_block_end;
    run.blk_len = in_block_end ? len_ext[erld_pkg::BLEN_W-1:0] : '0;
    run.trunc   = in_block_end && (phase_nxt != erld_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= erld_pkg::PH_IDLE;
      pend_r  <= '0;
      len_r   <= '0;
    end else if (take) begin
      if (in_block_end) begin
        phase_r <= erld_pkg::PH_IDLE;
        pend_r  <= '0;
        len_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        len_r   <= len_new;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/erld_emit.sv
// chunk emitter: one shared down-counter slices a run into lane chunks
`default_nettype none
module erld_emit #(
  parameter int LANES = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire erld_pkg::run_t                run,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte_0,
  output logic [7:0]                         out_byte_1,
  output logic [7:0]                         out_byte_2,
  output logic [7:0]                         out_byte_3,
  output logic [erld_pkg::CNT_W-1:0]         out_valid_count,
  output logic                               out_chunk_last,
  output logic                               out_block_done,
  output logic [erld_pkg::BLEN_W-1:0]        out_block_length,
  output logic                               out_truncated
);

  erld_pkg::emit_state_t            state_r, state_nxt;
  logic [7:0]                       val_r;
  logic [erld_pkg::RUN_W-1:0]       rem_r, rem_nxt, rem_left;
  logic [erld_pkg::CHUNK_W-1:0]     cnt_r, cnt_nxt;
  logic                             end_r;
  logic [erld_pkg::BLEN_W-1:0]      blen_r;
  logic                             trunc_r;

  logic                             step, emit, last;
  logic [erld_pkg::CNT_W-1:0]       n;

  logic                             ov_r, ov_nxt;
  logic [7:0]                       lane_r [erld_pkg::FIELD_LANES];
  logic [erld_pkg::CNT_W-1:0]       vc_r;
  logic                             cl_r, bd_r, tr_r;
  logic [erld_pkg::BLEN_W-1:0]      bl_r;

  assign step     = (state_r == erld_pkg::EM_RUN) && (!ov_r || !out_stall);
  assign n        = (rem_r < erld_pkg::RUN_W'(LANES)) ? rem_r[erld_pkg::CNT_W-1:0]
                                                      : erld_pkg::CNT_W'(LANES);
  assign rem_left = rem_r - erld_pkg::RUN_W'(n);
  // an empty run speaks only when it closes the block
  assign last     = (rem_left == '0) ||
                    (cnt_r == erld_pkg::CHUNK_W'(erld_pkg::MAX_RESULTS - 1));
  assign emit     = step && ((rem_r != '0) || end_r);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      state_nxt = erld_pkg::EM_RUN;
      rem_nxt   = run.len;
      cnt_nxt   = '0;
    end else if (step) begin
      rem_nxt = rem_left;
      cnt_nxt = cnt_r + erld_pkg::CHUNK_W'(1);
      if (last) state_nxt = erld_pkg::EM_IDLE;
    end
  end

  assign ov_nxt = emit ? 1'b1 : (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= erld_pkg::EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (load) begin
      val_r   <= run.value;
      end_r   <= run.blk_end;
      blen_r  <= run.blk_len;
      trunc_r <= run.trunc;
    end
    if (emit) begin
      for (int i = 0; i < erld_pkg::FIELD_LANES; i++) begin
        lane_r[i] <= (erld_pkg::CNT_W'(i) < n) ? val_r : 8'd0;
      end
      vc_r <= n;
      cl_r <= last;
      bd_r <= last && end_r;
      bl_r <= (last && end_r) ? blen_r : '0;
      tr_r <= last && end_r && trunc_r;
    end
  end

  assign busy             = (state_r == erld_pkg::EM_RUN);
  assign out_valid        = ov_r;
  assign out_byte_0       = lane_r[0];
  assign out_byte_1       = lane_r[1];
  assign out_byte_2       = lane_r[2];
  assign out_byte_3       = lane_r[3];
  assign out_valid_count  = vc_r;
  assign out_chunk_last   = cl_r;
  assign out_block_done   = bd_r;
  assign out_block_length = bl_r;
  assign out_truncated    = tr_r;

endmodule
`default_nettype wire

// File: design/escape_run_length_decoder_top.sv
// top level of the escape run-length decoder
//
// input channel: one compressed byte per beat (in_byte, in_block_end) under
//   in_valid / in_stall. 0xff opens an escape; the next byte is a count c.
//   c below 3 gives 0xff c+1 times, otherwise the byte after gives a run of
//   c+1 copies of itself. in_block_end marks the last byte of a block.
// output channel: chunks of up to OUT_LANES decoded bytes (at most 4) under
//   out_valid / out_stall, lanes filled from out_byte_0, unused lanes zero.
//   out_chunk_last marks the final chunk of one input byte; out_block_done
//   marks the final chunk of a block, with the saturating block length and
//   the truncation flag. an input that yields no bytes gives no beat unless
//   it ends the block, then one empty chunk carries the block status.
// timing: the parser state moves on the accept edge, where the emitter
//   loads the run; the emitter then moves one chunk per cycle into the
//   output register while that register is not held by out_stall. in_stall
//   stays high until the last chunk of the byte is registered, so a new
//   byte is not accepted while the emitter is still busy with the previous one.
// stall: a stalled output beat holds, and the emitter waits with it.
// reset: synchronous, active low; phase, length and emitter go idle.
`default_nettype none
module escape_run_length_decoder_top #(
  parameter int OUT_LANES   = 4,
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_block_end,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_byte_0,
  output logic [7:0]                          out_byte_1,
  output logic [7:0]                          out_byte_2,
  output logic [7:0]                          out_byte_3,
  output logic [erld_pkg::CNT_W-1:0]          out_valid_count,
  output logic                                out_chunk_last,
  output logic                                out_block_done,
  output logic [erld_pkg::BLEN_W-1:0]         out_block_length,
  output logic                                out_truncated
);

  // lanes actually used, clamped to the four payload lanes
  localparam int LANE_N = (OUT_LANES < 1) ? 1 :
                          ((OUT_LANES > erld_pkg::FIELD_LANES) ?
                           erld_pkg::FIELD_LANES : OUT_LANES);

  logic           take;
  logic           busy;
  erld_pkg::run_t run;

  // accept only while the emitter has nothing left of the previous byte
  assign in_stall = busy;
  assign take     = in_valid && !busy;

  erld_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_byte      (in_byte),
    .in_block_end (in_block_end),
    .run          (run)
  );

  erld_emit #(
    .LANES (LANE_N)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take),
    .run              (run),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_0       (out_byte_0),
    .out_byte_1       (out_byte_1),
    .out_byte_2       (out_byte_2),
    .out_byte_3       (out_byte_3),
    .out_valid_count  (out_valid_count),
    .out_chunk_last   (out_chunk_last),
    .out_block_done   (out_block_done),
    .out_block_length (out_block_length),
    .out_truncated    (out_truncated)
  );

`ifndef SYNTHESIS
  // an accepted byte always leaves the emitter busy in the following cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> in_stall)
    else $error("emitter not busy after accept");

  // only the final chunk of a byte may be partly filled
  a_full_chunks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_chunk_last) |-> (out_valid_count == erld_pkg::CNT_W'(LANE_N)))
    else $error("partial chunk before the last one");

  // block status only rides on the closing chunk
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_done) |-> out_chunk_last)
    else $error("block done on a non-final chunk");

  // an empty chunk exists only to close a block
  a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_valid_count == '0)) |-> out_block_done)
    else $error("empty chunk without block end");
`endif

endmodule
`default_nettype wire
